### rtl/core/jas_pkg.sv
// Shared types, constants and arithmetic helpers of the joystick axis shaper.
// Depends on nothing; every other file of rtl/core imports it.
package jas_pkg;

   localparam int AXIS_COUNT   = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int DIV_STEPS    = 15;

   localparam logic [14:0] FULL_SCALE = 15'h7FFF;
   localparam logic [3:0]  GEAR_DRIVE = 4'd4;

   typedef enum logic [2:0] {
      CSR_STEER_INDEX = 3'd0,
      CSR_BRAKE_INDEX = 3'd1,
      CSR_ACCEL_INDEX = 3'd2,
      CSR_INVERT_MASK = 3'd3,
      CSR_DEAD_BAND   = 3'd4,
      CSR_STEER_GAIN  = 3'd5,
      CSR_CURVE_MIX   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] axis_value_0;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_1;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_2;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_3;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_4;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_5;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_6;
      logic signed [SAMPLE_WIDTH-1:0] axis_value_7;
      logic [3:0]                     axis_count;
   } req_type;

   typedef struct packed {
      logic               status;
      logic signed [15:0] steer_out;
      logic [14:0]        brake_out;
      logic [14:0]        accel_out;
      logic [3:0]         gear_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  steer_index;
      logic [2:0]  brake_index;
      logic [2:0]  accel_index;
      logic [2:0]  invert_mask;
      logic [14:0] dead_band;
      logic [14:0] steer_gain;
      logic [14:0] curve_mix;
   } cfg_type;

   // Per-item control that rides along the back pipeline.
   typedef struct packed {
      logic        status;
      logic        neg;
      logic        zero;
      logic [14:0] brake;
      logic [14:0] accel;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [14:0] num;
   } work_type;

   typedef struct packed {
      logic [14:0] rem;
      logic [14:0] low;
      logic [14:0] quo;
   } div_type;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic div_type div_step(input div_type s, input logic [14:0] divisor);
      div_type     r;
      logic [15:0] part;
      logic [15:0] diff;
      logic        ge;
      part  = {s.rem, s.low[14]};
      diff  = part - {1'b0, divisor};
      ge    = (part >= {1'b0, divisor});
      r.rem = ge ? diff[14:0] : part[14:0];
      r.low = {s.low[13:0], 1'b0};
      r.quo = {s.quo[13:0], ge};
      return r;
   endfunction

   // Truncating divide by 2^15-1 for x <= FULL_SCALE^2, by folding the high part.
   function automatic logic [14:0] div_fs(input logic [29:0] x);
      logic [15:0] y;
      logic [15:0] y2;
      logic [15:0] q;
      y  = {1'b0, x[29:15]} + {1'b0, x[14:0]};
      y2 = {15'd0, y[15]} + {1'b0, y[14:0]};
      q  = {1'b0, x[29:15]} + {15'd0, y[15]} + {15'd0, (y2 >= {1'b0, FULL_SCALE})};
      return q[14:0];
   endfunction

endpackage

### rtl/core/jas_front.sv
// Front end: picks the configured axes of a frame, clamps, inverts, maps pedals
// and classifies steering. Depends on jas_pkg.
module jas_front (
   input  jas_pkg::cfg_type  cfg,
   input  jas_pkg::req_type  req_data,
   output jas_pkg::work_type work
);
   import jas_pkg::*;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic logic signed [15:0] clamp_sample(input logic signed [15:0] s);
      return (s == SAMPLE_MIN) ? (SAMPLE_MIN + 16'sd1) : s;
   endfunction

   function automatic logic [14:0] pedal_level(input logic signed [15:0] b, input logic inv);
      logic signed [16:0] ext;
      logic signed [16:0] sum;
      ext = {b[15], b};
      sum = inv ? (17'sd32767 - ext) : (17'sd32767 + ext);
      return sum[15:1];
   endfunction

   logic signed [15:0] axis [AXIS_COUNT];
   logic [3:0]         count;
   logic [2:0]         top_idx;
   logic               missing;
   logic signed [15:0] steer_b;
   logic signed [15:0] steer_s;
   logic [14:0]        mag;

   always_comb begin
      axis[0] = req_data.axis_value_0;
      axis[1] = req_data.axis_value_1;
      axis[2] = req_data.axis_value_2;
      axis[3] = req_data.axis_value_3;
      axis[4] = req_data.axis_value_4;
      axis[5] = req_data.axis_value_5;
      axis[6] = req_data.axis_value_6;
      axis[7] = req_data.axis_value_7;

      count = (req_data.axis_count > 4'(AXIS_COUNT)) ? 4'(AXIS_COUNT) : req_data.axis_count;
      top_idx = cfg.steer_index;
      if (cfg.brake_index > top_idx) begin
         top_idx = cfg.brake_index;
      end
      if (cfg.accel_index > top_idx) begin
         top_idx = cfg.accel_index;
      end
      missing = ({1'b0, top_idx} >= count);

      steer_b = clamp_sample(axis[cfg.steer_index]);
      steer_s = cfg.invert_mask[0] ? -steer_b : steer_b;
      mag     = steer_s[15] ? 15'(-steer_s) : steer_s[14:0];

      work.ctl.status = missing;
      work.ctl.neg    = steer_s[15];
      // inside the deadzone, or a deadzone covering full scale: no steering
      work.ctl.zero   = (mag <= cfg.dead_band) || (cfg.dead_band == FULL_SCALE);
      work.ctl.brake  = pedal_level(clamp_sample(axis[cfg.brake_index]), cfg.invert_mask[1]);
      work.ctl.accel  = pedal_level(clamp_sample(axis[cfg.accel_index]), cfg.invert_mask[2]);
      work.num        = mag - cfg.dead_band;
   end

endmodule

### rtl/core/jas_queue.sv
// Short item queue between the front end and the back pipeline.
// Depends on jas_pkg for the queued item type.
module jas_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jas_pkg::work_type push_data,
   input  logic              pop,
   output jas_pkg::work_type pop_data,
   output logic              full,
   output logic              empty
);
   import jas_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

### rtl/core/jas_div.sv
// Pipelined restoring divider for the deadzone renormalization, one quotient
// bit per stage. Depends on jas_pkg.
module jas_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  jas_pkg::ctl_type in_ctl,
   input  logic [14:0]      in_num,
   input  logic [14:0]      dead_band,
   output logic             out_valid,
   output jas_pkg::ctl_type out_ctl,
   output logic [14:0]      out_quo
);
   import jas_pkg::*;

   logic [14:0]          divisor;
   logic [29:0]          dividend;
   div_type              seed;
   div_type              step_ff [DIV_STEPS];
   div_type              step_in [DIV_STEPS];
   ctl_type              ctl_ff  [DIV_STEPS];
   ctl_type              ctl_in  [DIV_STEPS];
   logic [DIV_STEPS-1:0] vld_ff, vld_in;

   always_comb begin
      divisor  = FULL_SCALE - dead_band;
      // num * (2^15 - 1); its top half is below the divisor, so 15 steps suffice
      dividend = {in_num, 15'd0} - {15'd0, in_num};
      seed.rem = dividend[29:15];
      seed.low = dividend[14:0];
      seed.quo = '0;
      step_in[0] = div_step(seed, divisor);
      ctl_in[0]  = in_ctl;
      for (int k = 1; k < DIV_STEPS; k++) begin
         step_in[k] = div_step(step_ff[k-1], divisor);
         ctl_in[k]  = ctl_ff[k-1];
      end
      vld_in = {vld_ff[DIV_STEPS-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
         ctl_ff  <= ctl_in;
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_ctl   = ctl_ff[DIV_STEPS-1];
   assign out_quo   = step_ff[DIV_STEPS-1].quo;

endmodule

### rtl/core/jas_back.sv
// Back pipeline: cube, linear/cubic blend, gain, sign and the result register.
// Depends on jas_pkg.
module jas_back (
   input  logic             clock,
   input  logic             reset,
   input  jas_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  jas_pkg::ctl_type in_ctl,
   input  logic [14:0]      in_n,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output jas_pkg::rsp_type rsp_data,
   output logic             advance
);
   import jas_pkg::*;

   localparam int STAGES = 11;
   localparam int N_TAPS = 6;

   logic [STAGES-1:0] vld_ff;
   ctl_type           ctl_ff [STAGES];
   logic [14:0]       n_ff   [N_TAPS];

   logic [29:0] sq_ff, sq_in;
   logic [44:0] cubed_ff, cubed_in;
   logic [29:0] acc_ff, acc_in;
   logic [30:0] fold_ff, fold_in;
   logic [29:0] acc2_ff, acc2_in;
   logic [16:0] fold2_ff, fold2_in;
   logic [1:0]  fold3_hi;
   logic [15:0] fold3;
   logic [29:0] q1_ff, q1_in;
   logic [14:0] cube_ff, cube_in;
   logic [29:0] lin_ff, lin_in;
   logic [29:0] cub_ff, cub_in;
   logic [29:0] sum_ff, sum_in;
   logic [14:0] curved_ff, curved_in;
   logic [29:0] prod_ff, prod_in;
   logic [14:0] mag_ff, mag_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [15:0] steer_mag;
   ctl_type     last_ctl;

   // hold everything while a finished result waits on the receiver
   assign advance = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      sq_in    = 30'(in_n) * 30'(in_n);
      cubed_in = 45'(sq_ff) * 45'(n_ff[0]);
      // n^3 / (2^15-1): fold the 2^15 multiples back in, three times
      acc_in   = cubed_ff[44:15];
      fold_in  = {1'b0, cubed_ff[44:15]} + 31'(cubed_ff[14:0]);
      acc2_in  = acc_ff + 30'(fold_ff[30:15]);
      fold2_in = 17'(fold_ff[30:15]) + 17'(fold_ff[14:0]);
      fold3_hi = fold2_ff[16:15];
      fold3    = 16'(fold3_hi) + 16'(fold2_ff[14:0]);
      q1_in    = acc2_ff + 30'(fold3_hi) + 30'(fold3 >= {1'b0, FULL_SCALE});
      cube_in  = div_fs(q1_ff);
      lin_in   = 30'(FULL_SCALE - cfg.curve_mix) * 30'(n_ff[N_TAPS-1]);
      cub_in   = 30'(cfg.curve_mix) * 30'(cube_ff);
      sum_in   = lin_ff + cub_ff;
      curved_in = div_fs(sum_ff);
      prod_in  = 30'(curved_ff) * 30'(cfg.steer_gain);
      mag_in   = div_fs(prod_ff);
   end

   always_comb begin
      last_ctl  = ctl_ff[STAGES-1];
      steer_mag = {1'b0, mag_ff};
      rsp_data_in = '0;
      rsp_data_in.status = last_ctl.status;
      if (!last_ctl.status) begin
         if (last_ctl.zero) begin
            rsp_data_in.steer_out = '0;
         end else begin
            rsp_data_in.steer_out = last_ctl.neg ? -steer_mag : steer_mag;
         end
         rsp_data_in.brake_out = last_ctl.brake;
         rsp_data_in.accel_out = last_ctl.accel;
         rsp_data_in.gear_out  = GEAR_DRIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[STAGES-2:0], in_valid};
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= in_ctl;
         for (int k = 1; k < STAGES; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         n_ff[0] <= in_n;
         for (int k = 1; k < N_TAPS; k++) begin
            n_ff[k] <= n_ff[k-1];
         end
         sq_ff       <= sq_in;
         cubed_ff    <= cubed_in;
         acc_ff      <= acc_in;
         fold_ff     <= fold_in;
         acc2_ff     <= acc2_in;
         fold2_ff    <= fold2_in;
         q1_ff       <= q1_in;
         cube_ff     <= cube_in;
         lin_ff      <= lin_in;
         cub_ff      <= cub_in;
         sum_ff      <= sum_in;
         curved_ff   <= curved_in;
         prod_ff     <= prod_in;
         mag_ff      <= mag_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/joystick_axis_shaper.sv
// Joystick axis shaper: maps one joystick frame to steering, brake, accelerator
// and gear commands.
// req_*: one frame per item (eight Q15 axes and a valid-axis count); taken at a
//   clock edge with req_valid high and req_stall low.
// rsp_*: one result per frame, in order; delivered with rsp_valid high and
//   rsp_stall low. A frame naming an axis beyond the count gives status 1 and
//   zero outputs.
// csr_*: register writes (index, data), always ready; write only while idle.
// Path: an accepted frame passes the queue, the 15-stage divider for the deadzone
//   rescale and the 11-stage cube/blend/gain pipeline to the result register.
// Throughput: one frame per cycle while the receiver takes results.
// Receiver stall: the result register and the whole back pipeline hold; the
//   front queue of QUEUE_DEPTH items keeps accepting until it fills, then
//   req_stall rises.
// Reset (synchronous): empties queue and pipeline, restores register defaults
//   (steer axis 0, brake 1, accelerator 2, no inversion, no deadzone, full gain,
//   linear response).
module joystick_axis_shaper #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jas_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jas_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [14:0]      csr_wdata
);
   import jas_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   work_type front_work;
   work_type queue_work;
   logic     queue_full;
   logic     queue_empty;
   logic     push;
   logic     pop;
   logic     advance;
   logic     div_valid;
   ctl_type  div_ctl;
   logic [14:0] div_quo;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEER_INDEX: cfg_in.steer_index = csr_wdata[2:0];
            CSR_BRAKE_INDEX: cfg_in.brake_index = csr_wdata[2:0];
            CSR_ACCEL_INDEX: cfg_in.accel_index = csr_wdata[2:0];
            CSR_INVERT_MASK: cfg_in.invert_mask = csr_wdata[2:0];
            CSR_DEAD_BAND:   cfg_in.dead_band   = csr_wdata;
            CSR_STEER_GAIN:  cfg_in.steer_gain  = csr_wdata;
            CSR_CURVE_MIX:   cfg_in.curve_mix   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steer_index <= 3'd0;
         cfg_ff.brake_index <= 3'd1;
         cfg_ff.accel_index <= 3'd2;
         cfg_ff.invert_mask <= 3'd0;
         cfg_ff.dead_band   <= 15'd0;
         cfg_ff.steer_gain  <= FULL_SCALE;
         cfg_ff.curve_mix   <= 15'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign pop       = advance && !queue_empty;

   jas_front u_front (
      .cfg      (cfg_ff),
      .req_data (req_data),
      .work     (front_work)
   );

   jas_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_work),
      .pop       (pop),
      .pop_data  (queue_work),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   jas_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (!queue_empty),
      .in_ctl    (queue_work.ctl),
      .in_num    (queue_work.num),
      .dead_band (cfg_ff.dead_band),
      .out_valid (div_valid),
      .out_ctl   (div_ctl),
      .out_quo   (div_quo)
   );

   jas_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_ctl    (div_ctl),
      .in_n      (div_quo),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .advance   (advance)
   );

endmodule

### test/axis_shaper_checker.sv
`timescale 1ns / 100ps
// Result checker of the joystick axis shaper: mirrors the block's registers,
// predicts the command of every accepted frame and compares results in order.
// Depends on jas_pkg for the item, result and register types.
module axis_shaper_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  jas_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  jas_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [14:0]      csr_wdata,
   output int               mismatches,
   output int               cmds_pending
);
   import jas_pkg::*;

   localparam int FS = 32767;

   localparam cfg_type REGS_AT_RESET = '{
      steer_index: 3'd0, brake_index: 3'd1, accel_index: 3'd2, invert_mask: 3'd0,
      dead_band: 15'd0, steer_gain: 15'h7FFF, curve_mix: 15'd0};

   cfg_type shaper_regs;
   rsp_type expected_cmds[$];
   rsp_type want;

   function automatic int clamp_q15(logic signed [15:0] s);
      int v;
      v = s;
      return (v < -FS) ? -FS : v;
   endfunction

   function automatic int pedal_level(int b, logic inv);
      return inv ? (FS - b) / 2 : (b + FS) / 2;
   endfunction

   function automatic rsp_type shape_frame(req_type f, cfg_type c);
      logic signed [15:0] axes [AXIS_COUNT];
      int      present;
      int      top;
      longint  b, m, d, e, g, n, cube, curved, mag;
      rsp_type r;
      axes = '{f.axis_value_0, f.axis_value_1, f.axis_value_2, f.axis_value_3,
               f.axis_value_4, f.axis_value_5, f.axis_value_6, f.axis_value_7};
      present = (f.axis_count > AXIS_COUNT) ? AXIS_COUNT : int'(f.axis_count);
      top = c.steer_index;
      if (c.brake_index > top) top = c.brake_index;
      if (c.accel_index > top) top = c.accel_index;
      r = '0;
      // a configured axis beyond the count: error status, all outputs zero
      if (top >= present) begin
         r.status = 1'b1;
         return r;
      end
      b = clamp_q15(axes[c.steer_index]);
      if (c.invert_mask[0]) b = -b;
      m = (b < 0) ? -b : b;
      d = c.dead_band;
      e = c.curve_mix;
      g = c.steer_gain;
      mag = 0;
      // deadzone at full scale means no divide and no steering
      if (m > d && d < FS) begin
         n      = (m - d) * FS / (FS - d);
         cube   = n * n * n / (longint'(FS) * FS);
         curved = ((FS - e) * n + e * cube) / FS;
         mag    = curved * g / FS;
      end
      r.steer_out = 16'((b < 0) ? -mag : mag);
      r.brake_out = 15'(pedal_level(clamp_q15(axes[c.brake_index]), c.invert_mask[1]));
      r.accel_out = 15'(pedal_level(clamp_q15(axes[c.accel_index]), c.invert_mask[2]));
      r.gear_out  = GEAR_DRIVE;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp_val);
      if (mismatches < 40)
         $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shaper_regs = REGS_AT_RESET;
         expected_cmds.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEER_INDEX: shaper_regs.steer_index = csr_wdata[2:0];
               CSR_BRAKE_INDEX: shaper_regs.brake_index = csr_wdata[2:0];
               CSR_ACCEL_INDEX: shaper_regs.accel_index = csr_wdata[2:0];
               CSR_INVERT_MASK: shaper_regs.invert_mask = csr_wdata[2:0];
               CSR_DEAD_BAND:   shaper_regs.dead_band   = csr_wdata;
               CSR_STEER_GAIN:  shaper_regs.steer_gain  = csr_wdata;
               CSR_CURVE_MIX:   shaper_regs.curve_mix   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_cmds.push_back(shape_frame(req_data, shaper_regs));
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("result with no frame pending, status", rsp_data.status, 0);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.steer_out !== want.steer_out)
                  report_mismatch("steer_out", rsp_data.steer_out, want.steer_out);
               if (rsp_data.brake_out !== want.brake_out)
                  report_mismatch("brake_out", rsp_data.brake_out, want.brake_out);
               if (rsp_data.accel_out !== want.accel_out)
                  report_mismatch("accel_out", rsp_data.accel_out, want.accel_out);
               if (rsp_data.gear_out !== want.gear_out)
                  report_mismatch("gear_out", rsp_data.gear_out, want.gear_out);
            end
         end
      end
      cmds_pending = expected_cmds.size();
   end

endmodule

### test/tb_joystick_axis_shaper.sv
`timescale 1ns / 100ps
// Testbench top of the joystick axis shaper: clock, reset, frame and register
// stimulus, result-side stalls and the verdict.
// Depends on jas_pkg, joystick_axis_shaper and axis_shaper_checker.
module tb_joystick_axis_shaper;
   import jas_pkg::*;

   localparam int FS = 32767;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [14:0] csr_wdata;
   int          mismatches;
   int          cmds_pending;

   cfg_type shaper_cfg;
   bit      idling_on;
   bit      hold_off_pending;
   bit      hold_off_done;

   joystick_axis_shaper uut (.*);

   axis_shaper_checker cmd_check (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stall bursts, or one long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [15:0] random_sample(int band);
      int v;
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 1) ? FS : -32768;
         1: v = int'($urandom_range(0, 2)) - 1;
         2: begin
            // land right around the deadzone edge
            v = band + int'($urandom_range(0, 4)) - 2;
            if (v > FS) v = FS;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return v[15:0];
   endfunction

   function automatic req_type make_frame(cfg_type c);
      req_type f;
      int      top;
      top = c.steer_index;
      if (c.brake_index > top) top = c.brake_index;
      if (c.accel_index > top) top = c.accel_index;
      f.axis_value_0 = random_sample(c.dead_band);
      f.axis_value_1 = random_sample(c.dead_band);
      f.axis_value_2 = random_sample(c.dead_band);
      f.axis_value_3 = random_sample(c.dead_band);
      f.axis_value_4 = random_sample(c.dead_band);
      f.axis_value_5 = random_sample(c.dead_band);
      f.axis_value_6 = random_sample(c.dead_band);
      f.axis_value_7 = random_sample(c.dead_band);
      // mostly frames that carry every configured axis
      if ($urandom_range(0, 4) == 0) f.axis_count = 4'($urandom_range(0, 15));
      else f.axis_count = 4'($urandom_range(top + 1, 15));
      return f;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.steer_index = 3'($urandom_range(0, 7));
      c.brake_index = 3'($urandom_range(0, 7));
      c.accel_index = 3'($urandom_range(0, 7));
      c.invert_mask = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: c.dead_band = 15'd0;
         1: c.dead_band = 15'($urandom_range(0, 2000));
         2: c.dead_band = 15'($urandom_range(0, FS));
         default: c.dead_band = 15'($urandom_range(30000, FS));
      endcase
      c.steer_gain = ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom_range(1, FS));
      c.curve_mix  = 15'($urandom_range(0, FS));
      return c;
   endfunction

   function automatic req_type uniform_frame(logic signed [15:0] v, logic [3:0] count);
      req_type f;
      f = {{AXIS_COUNT{v}}, count};
      return f;
   endfunction

   // call right after a rising edge
   task automatic send_frame(req_type f);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the frame side until every predicted command has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (cmds_pending == 0);
      @(posedge clock);
   endtask

   task automatic write_cfg(cfg_type c);
      csr_index_type idx;
      logic [14:0]   val;
      idx = idx.first();
      do begin
         case (idx)
            CSR_STEER_INDEX: val = c.steer_index;
            CSR_BRAKE_INDEX: val = c.brake_index;
            CSR_ACCEL_INDEX: val = c.accel_index;
            CSR_INVERT_MASK: val = c.invert_mask;
            CSR_DEAD_BAND:   val = c.dead_band;
            CSR_STEER_GAIN:  val = c.steer_gain;
            default:         val = c.curve_mix;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end while (idx != idx.first());
      csr_valid <= 1'b0;
      shaper_cfg = c;
   endtask

   initial begin
      req_type f;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_STEER_INDEX;
      csr_wdata        = '0;
      idling_on        = 1'b1;
      hold_off_pending = 1'b0;
      shaper_cfg = '{steer_index: 3'd0, brake_index: 3'd1, accel_index: 3'd2,
                     invert_mask: 3'd0, dead_band: 15'd0, steer_gain: 15'h7FFF,
                     curve_mix: 15'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults: sample extremes, missing axes, counts above eight
      send_frame(uniform_frame(16'sd0, 4'd8));
      f = uniform_frame(16'sd32767, 4'd8);
      f.axis_value_1 = -16'sd32768;
      send_frame(f);
      f = uniform_frame(-16'sd32768, 4'd8);
      f.axis_value_2 = -16'sd32767;
      send_frame(f);
      f = uniform_frame(16'sd1, 4'd3);
      f.axis_value_0 = -16'sd1;
      send_frame(f);
      send_frame(uniform_frame(-16'sd32768, 4'd2));
      send_frame(uniform_frame(16'sd20000, 4'd0));
      send_frame(uniform_frame(-16'sd12345, 4'd9));
      f = uniform_frame(16'sd32767, 4'd15);
      f.axis_value_0 = -16'sd32768;
      send_frame(f);

      // top axes, everything inverted, widest deadzone below full scale, full cube
      drain();
      write_cfg('{steer_index: 3'd7, brake_index: 3'd5, accel_index: 3'd3,
                  invert_mask: 3'd7, dead_band: 15'd32766, steer_gain: 15'h7FFF,
                  curve_mix: 15'h7FFF});
      send_frame(uniform_frame(16'sd32767, 4'd7));
      send_frame(uniform_frame(-16'sd32768, 4'd8));
      f = uniform_frame(16'sd32767, 4'd8);
      f.axis_value_7 = 16'sd32766;
      send_frame(f);
      f = uniform_frame(-16'sd32767, 4'd8);
      f.axis_value_7 = 16'sd0;
      send_frame(f);

      // deadzone at full scale with zero gain
      drain();
      write_cfg('{steer_index: 3'd0, brake_index: 3'd1, accel_index: 3'd2,
                  invert_mask: 3'd0, dead_band: 15'h7FFF, steer_gain: 15'd0,
                  curve_mix: 15'd0});
      send_frame(uniform_frame(16'sd32767, 4'd8));
      send_frame(uniform_frame(-16'sd32768, 4'd8));

      // half deadzone, smallest nonzero gain, half blend
      drain();
      write_cfg('{steer_index: 3'd3, brake_index: 3'd4, accel_index: 3'd6,
                  invert_mask: 3'd1, dead_band: 15'd16384, steer_gain: 15'd1,
                  curve_mix: 15'd16384});
      f = uniform_frame(16'sd0, 4'd8);
      f.axis_value_3 = 16'sd16384;
      send_frame(f);
      f.axis_value_3 = -16'sd16385;
      send_frame(f);
      f.axis_value_3 = -16'sd32768;
      send_frame(f);

      for (int p = 0; p < 8; p++) begin
         drain();
         write_cfg(random_cfg());
         // no idling in the first phase, the long hold phase and the last one
         idling_on = (p != 0) && (p != 3) && (p != 7);
         if (p == 3) hold_off_pending = 1'b1;
         for (int k = 0; k < 105; k++) begin
            if (p == 5 && k == 50) drain();
            send_frame(make_frame(shaper_cfg));
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
